FILE: src/hfl_pkg.sv
`timescale 1ns / 1ps

package hfl_pkg;

  // fraction bits of every fixed-point field
  localparam int FRAC_BITS = 16;

  localparam int HW      = 32;                // entry / principal point width
  localparam int PW      = 2 * HW;            // 32x32 product
  localparam int SW      = PW + 2;            // sums of up to six products
  localparam int DW      = 100;               // det, su, sv, b
  localparam int BMAG_W  = 98;                // |b| < 2^98
  localparam int NUM_W   = BMAG_W + FRAC_BITS; // dividend and quotient width
  localparam int REM_W   = PW;                // divisor and remainder width
  localparam int F2_W    = NUM_W + 2;         // signed squared focal
  localparam int ROOT_W  = 32;                // result width
  localparam int RAD_W   = 2 * ROOT_W;        // radicand width
  localparam int SREM_W  = ROOT_W + 2;        // root remainder width
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_Y = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEG_DET   = 2'd1,
    ST_NEG_F2    = 2'd2,
    ST_ZERO_COEF = 2'd3
  } status_t;

  // side data that rides along the divider
  typedef struct packed {
    status_t          status;
    logic             neg;
    logic [PW-1:0]    uv2;
  } div_meta_t;

  function automatic logic signed [PW-1:0] smul(input logic signed [HW-1:0] a,
                                                input logic signed [HW-1:0] b);
    smul = a * b;
  endfunction

  // upper partial product: a * s[SW-1:HW]
  function automatic logic signed [SW-1:0] mul_hi(input logic signed [HW-1:0] a,
                                                  input logic signed [SW-1:0] s);
    mul_hi = a * $signed(s[SW-1:HW]);
  endfunction

  // lower partial product: a * unsigned s[HW-1:0]
  function automatic logic signed [SW-1:0] mul_lo(input logic signed [HW-1:0] a,
                                                  input logic signed [SW-1:0] s);
    mul_lo = a * $signed({1'b0, s[HW-1:0]});
  endfunction

  function automatic logic signed [DW-1:0] join_pp(input logic signed [SW-1:0] hi,
                                                   input logic signed [SW-1:0] lo);
    join_pp = (DW'(hi) <<< HW) + DW'(lo);
  endfunction

endpackage

FILE: src/hfl_front.sv
`timescale 1ns / 1ps

module hfl_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [hfl_pkg::HW-1:0]        h [9],
  input  logic signed [hfl_pkg::HW-1:0]        u0,
  input  logic signed [hfl_pkg::HW-1:0]        v0,
  output logic                                 div_valid,
  output logic [hfl_pkg::NUM_W-1:0]            div_num,
  output logic [hfl_pkg::REM_W-1:0]            div_den,
  output hfl_pkg::div_meta_t                   div_meta
);

  localparam int HW = hfl_pkg::HW;
  localparam int PW = hfl_pkg::PW;
  localparam int SW = hfl_pkg::SW;
  localparam int DW = hfl_pkg::DW;

  // stage 1: all 32x32 products
  logic                 v1_r;
  logic signed [PW-1:0] m48_r, m57_r, m38_r, m56_r, m37_r, m46_r;
  logic signed [PW-1:0] m77_r, m67_r, m66_r;
  logic signed [PW-1:0] m01_r, m34_r, m00_r, m33_r, m11_r, m44_r;
  logic signed [PW-1:0] m07_r, m61_r, m06_r, m17_r, m36_r, m47_r;
  logic [PW-1:0]        uu_r, vv_r;
  logic signed [HW-1:0] h0_1_r, h1_1_r, h2_1_r, u0_1_r, v0_1_r;

  // stage 2: sums of products
  logic                 v2_r;
  logic signed [SW-1:0] d0_r, d1_r, d2_r, a2_r, q2_r, sui_r, svi_r;
  logic [PW-1:0]        uv2_2_r;
  logic signed [HW-1:0] h0_2_r, h1_2_r, h2_2_r, u0_2_r, v0_2_r;

  // stage 3: split partial products
  logic                 v3_r;
  logic signed [SW-1:0] p0h_r, p0l_r, p1h_r, p1l_r, p2h_r, p2l_r;
  logic signed [SW-1:0] suh_r, sul_r, svh_r, svl_r, a3_r, q3_r;
  logic [PW-1:0]        uv2_3_r;

  // stage 4: assembled wide terms
  logic                 v4_r;
  logic signed [DW-1:0] det_r, su_r, sv_r;
  logic signed [SW-1:0] a4_r, q4_r;
  logic [PW-1:0]        uv2_4_r;

  // stage 5: right side, early status
  logic                 v5_r;
  logic signed [DW-1:0] b_r;
  logic signed [SW-1:0] a5_r;
  logic [PW-1:0]        uv2_5_r;
  hfl_pkg::status_t     st5_r;

  // stage 5 and 6 comb, stage 6 registers
  logic                 b_neg, a_neg;
  logic signed [DW-1:0] bmag_nxt;
  logic signed [SW-1:0] amag_nxt;
  hfl_pkg::status_t     st4_nxt;

  logic                 v6_r;
  logic [hfl_pkg::NUM_W-1:0] num_r;
  logic [hfl_pkg::REM_W-1:0] den_r;
  hfl_pkg::div_meta_t   meta_r;

  always_comb begin
    b_neg    = b_r[DW-1];
    a_neg    = a5_r[SW-1];
    bmag_nxt = b_neg ? -b_r : b_r;
    amag_nxt = a_neg ? -a5_r : a5_r;
    if (det_r[DW-1]) begin
      st4_nxt = hfl_pkg::ST_NEG_DET;
    end else if (a4_r == '0) begin
      st4_nxt = hfl_pkg::ST_ZERO_COEF;
    end else begin
      st4_nxt = hfl_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      m48_r <= hfl_pkg::smul(h[4], h[8]);
      m57_r <= hfl_pkg::smul(h[5], h[7]);
      m38_r <= hfl_pkg::smul(h[3], h[8]);
      m56_r <= hfl_pkg::smul(h[5], h[6]);
      m37_r <= hfl_pkg::smul(h[3], h[7]);
      m46_r <= hfl_pkg::smul(h[4], h[6]);
      m77_r <= hfl_pkg::smul(h[7], h[7]);
      m67_r <= hfl_pkg::smul(h[6], h[7]);
      m66_r <= hfl_pkg::smul(h[6], h[6]);
      m01_r <= hfl_pkg::smul(h[0], h[1]);
      m34_r <= hfl_pkg::smul(h[3], h[4]);
      m00_r <= hfl_pkg::smul(h[0], h[0]);
      m33_r <= hfl_pkg::smul(h[3], h[3]);
      m11_r <= hfl_pkg::smul(h[1], h[1]);
      m44_r <= hfl_pkg::smul(h[4], h[4]);
      m07_r <= hfl_pkg::smul(h[0], h[7]);
      m61_r <= hfl_pkg::smul(h[6], h[1]);
      m06_r <= hfl_pkg::smul(h[0], h[6]);
      m17_r <= hfl_pkg::smul(h[1], h[7]);
      m36_r <= hfl_pkg::smul(h[3], h[6]);
      m47_r <= hfl_pkg::smul(h[4], h[7]);
      uu_r  <= hfl_pkg::smul(u0, u0);
      vv_r  <= hfl_pkg::smul(v0, v0);
      h0_1_r <= h[0];
      h1_1_r <= h[1];
      h2_1_r <= h[2];
      u0_1_r <= u0;
      v0_1_r <= v0;

      // stage 2
      d0_r  <= SW'(m48_r) - SW'(m57_r);
      d1_r  <= SW'(m38_r) - SW'(m56_r);
      d2_r  <= SW'(m37_r) - SW'(m46_r);
      a2_r  <= SW'(m77_r) - SW'(m67_r) - SW'(m66_r);
      q2_r  <= SW'(m01_r) + SW'(m34_r) + SW'(m00_r) + SW'(m33_r)
               - SW'(m11_r) - SW'(m44_r);
      sui_r <= SW'(m07_r) + SW'(m61_r) + (SW'(m06_r) <<< 1) - (SW'(m17_r) <<< 1);
      svi_r <= SW'(m37_r) + SW'(m46_r) + (SW'(m36_r) <<< 1) - (SW'(m47_r) <<< 1);
      uv2_2_r <= uu_r + vv_r;
      h0_2_r <= h0_1_r;
      h1_2_r <= h1_1_r;
      h2_2_r <= h2_1_r;
      u0_2_r <= u0_1_r;
      v0_2_r <= v0_1_r;

      // stage 3
      p0h_r <= hfl_pkg::mul_hi(h0_2_r, d0_r);
      p0l_r <= hfl_pkg::mul_lo(h0_2_r, d0_r);
      p1h_r <= hfl_pkg::mul_hi(h1_2_r, d1_r);
      p1l_r <= hfl_pkg::mul_lo(h1_2_r, d1_r);
      p2h_r <= hfl_pkg::mul_hi(h2_2_r, d2_r);
      p2l_r <= hfl_pkg::mul_lo(h2_2_r, d2_r);
      suh_r <= hfl_pkg::mul_hi(u0_2_r, sui_r);
      sul_r <= hfl_pkg::mul_lo(u0_2_r, sui_r);
      svh_r <= hfl_pkg::mul_hi(v0_2_r, svi_r);
      svl_r <= hfl_pkg::mul_lo(v0_2_r, svi_r);
      a3_r  <= a2_r;
      q3_r  <= q2_r;
      uv2_3_r <= uv2_2_r;

      // stage 4
      det_r <= hfl_pkg::join_pp(p0h_r, p0l_r) - hfl_pkg::join_pp(p1h_r, p1l_r)
               + hfl_pkg::join_pp(p2h_r, p2l_r);
      su_r  <= hfl_pkg::join_pp(suh_r, sul_r);
      sv_r  <= hfl_pkg::join_pp(svh_r, svl_r);
      a4_r  <= a3_r;
      q4_r  <= q3_r;
      uv2_4_r <= uv2_3_r;

      // stage 5
      b_r     <= (DW'(q4_r) <<< hfl_pkg::FRAC_BITS) - su_r - sv_r;
      a5_r    <= a4_r;
      uv2_5_r <= uv2_4_r;
      st5_r   <= st4_nxt;

      // stage 6: magnitudes for the unsigned divider
      num_r        <= {bmag_nxt[hfl_pkg::BMAG_W-1:0], {hfl_pkg::FRAC_BITS{1'b0}}};
      den_r        <= amag_nxt[hfl_pkg::REM_W-1:0];
      meta_r.status <= st5_r;
      meta_r.neg    <= b_neg ^ a_neg;
      meta_r.uv2    <= uv2_5_r;
    end
  end

  assign div_valid = v6_r;
  assign div_num   = num_r;
  assign div_den   = den_r;
  assign div_meta  = meta_r;

endmodule

FILE: src/hfl_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage
module hfl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hfl_pkg::NUM_W-1:0]     num,
  input  logic [hfl_pkg::REM_W-1:0]     den,
  input  hfl_pkg::div_meta_t            meta,
  output logic                          quo_valid,
  output logic [hfl_pkg::NUM_W-1:0]     quo,
  output hfl_pkg::div_meta_t            quo_meta
);

  localparam int NW = hfl_pkg::NUM_W;
  localparam int RW = hfl_pkg::REM_W;

  logic               v_r    [NW];
  logic [RW-1:0]      rem_r  [NW];
  logic [NW-1:0]      nq_r   [NW];   // dividend bits out the top, quotient in
  logic [RW-1:0]      den_r  [NW];
  hfl_pkg::div_meta_t meta_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic               v_src;
    logic [RW-1:0]      rem_src;
    logic [NW-1:0]      nq_src;
    logic [RW-1:0]      den_src;
    hfl_pkg::div_meta_t meta_src;
    logic [RW:0]        trial;
    logic [RW:0]        diff;
    logic               ge;

    if (k == 0) begin : g_first
      always_comb begin
        v_src    = in_valid;
        rem_src  = '0;
        nq_src   = num;
        den_src  = den;
        meta_src = meta;
      end
    end else begin : g_next
      always_comb begin
        v_src    = v_r[k-1];
        rem_src  = rem_r[k-1];
        nq_src   = nq_r[k-1];
        den_src  = den_r[k-1];
        meta_src = meta_r[k-1];
      end
    end

    always_comb begin
      trial = {rem_src, nq_src[NW-1]};
      diff  = trial - {1'b0, den_src};
      ge    = (trial >= {1'b0, den_src});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
        nq_r[k]   <= {nq_src[NW-2:0], ge};
        den_r[k]  <= den_src;
        meta_r[k] <= meta_src;
      end
    end
  end

  assign quo_valid = v_r[NW-1];
  assign quo       = nq_r[NW-1];
  assign quo_meta  = meta_r[NW-1];

endmodule

FILE: src/hfl_sqrt.sv
`timescale 1ns / 1ps

// signed quotient, squared focal, status, then digit-by-digit square root
module hfl_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hfl_pkg::NUM_W-1:0]     quo,
  input  hfl_pkg::div_meta_t            meta,
  output logic                          res_valid,
  output logic [hfl_pkg::ROOT_W-1:0]    res_focal,
  output hfl_pkg::status_t              res_status
);

  localparam int F2W = hfl_pkg::F2_W;
  localparam int RTW = hfl_pkg::ROOT_W;
  localparam int RDW = hfl_pkg::RAD_W;
  localparam int SRW = hfl_pkg::SREM_W;

  // stage A: x and f2
  logic                  va_r;
  logic signed [F2W-1:0] f2_r;
  hfl_pkg::status_t      sta_r;
  logic signed [F2W-1:0] x_nxt;

  // stage B: status and radicand
  logic                  vb_r;
  logic [RDW-1:0]        rad_r;
  logic                  satb_r;
  hfl_pkg::status_t      stb_r;
  hfl_pkg::status_t      stb_nxt;

  always_comb begin
    x_nxt = meta.neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    if (sta_r == hfl_pkg::ST_OK && f2_r[F2W-1]) begin
      stb_nxt = hfl_pkg::ST_NEG_F2;
    end else begin
      stb_nxt = sta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r   <= x_nxt - $signed({{(F2W - hfl_pkg::PW){1'b0}}, meta.uv2});
      sta_r  <= meta.status;
      rad_r  <= f2_r[RDW-1:0];
      satb_r <= |f2_r[F2W-1:RDW];
      stb_r  <= stb_nxt;
    end
  end

  // root stages
  logic             v_r    [RTW];
  logic [SRW-1:0]   rem_r  [RTW];
  logic [RTW-1:0]   root_r [RTW];
  logic [RDW-1:0]   rad_sr [RTW];
  logic             sat_r  [RTW];
  hfl_pkg::status_t st_r   [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_root
    logic             v_src;
    logic [SRW-1:0]   rem_src;
    logic [RTW-1:0]   root_src;
    logic [RDW-1:0]   rad_src;
    logic             sat_src;
    hfl_pkg::status_t st_src;
    logic [SRW+1:0]   cur;
    logic [SRW+1:0]   trial;
    logic [SRW+1:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      always_comb begin
        v_src    = vb_r;
        rem_src  = '0;
        root_src = '0;
        rad_src  = rad_r;
        sat_src  = satb_r;
        st_src   = stb_r;
      end
    end else begin : g_next
      always_comb begin
        v_src    = v_r[k-1];
        rem_src  = rem_r[k-1];
        root_src = root_r[k-1];
        rad_src  = rad_sr[k-1];
        sat_src  = sat_r[k-1];
        st_src   = st_r[k-1];
      end
    end

    always_comb begin
      cur   = {rem_src, rad_src[RDW-1:RDW-2]};
      trial = {{(SRW - RTW){1'b0}}, root_src, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[SRW-1:0] : cur[SRW-1:0];
        root_r[k] <= {root_src[RTW-2:0], ge};
        rad_sr[k] <= {rad_src[RDW-3:0], 2'b00};
        sat_r[k]  <= sat_src;
        st_r[k]   <= st_src;
      end
    end
  end

  // output register
  logic             vo_r;
  logic [RTW-1:0]   focal_r;
  hfl_pkg::status_t sto_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sto_r <= st_r[RTW-1];
      if (st_r[RTW-1] != hfl_pkg::ST_OK) begin
        focal_r <= '0;
      end else if (sat_r[RTW-1]) begin
        focal_r <= '1;
      end else begin
        focal_r <= root_r[RTW-1];
      end
    end
  end

  assign res_valid  = vo_r;
  assign res_focal  = focal_r;
  assign res_status = sto_r;

endmodule

FILE: src/focal_length_from_homography_unit.sv
`timescale 1ns / 1ps

// Focal length from a plane homography. Each input word is a 3x3 homography
// in signed Q16.16; each output word is the focal length (unsigned Q16.16,
// saturated to all ones) and a status: ok, negative determinant, negative
// squared focal, or zero coefficient (focal length is zero unless ok). The
// principal point comes from two config registers (index 0 = x, index 1 = y),
// to be written only while the block is empty. One word is taken per clock
// unless the output is stalled, and results come out in order. The pipeline
// is six multiply/add stages, a restoring divider that resolves one quotient
// bit per stage, two setup stages, a 32-stage square root and the output
// register. A stalled output holds the whole pipeline; nothing is dropped or
// duplicated.
module focal_length_from_homography_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hfl_pkg::HW-1:0]      in_h00,
  input  logic signed [hfl_pkg::HW-1:0]      in_h01,
  input  logic signed [hfl_pkg::HW-1:0]      in_h02,
  input  logic signed [hfl_pkg::HW-1:0]      in_h10,
  input  logic signed [hfl_pkg::HW-1:0]      in_h11,
  input  logic signed [hfl_pkg::HW-1:0]      in_h12,
  input  logic signed [hfl_pkg::HW-1:0]      in_h20,
  input  logic signed [hfl_pkg::HW-1:0]      in_h21,
  input  logic signed [hfl_pkg::HW-1:0]      in_h22,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hfl_pkg::ROOT_W-1:0]         out_focal_length,
  output logic [1:0]                         out_status,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hfl_pkg::HW-1:0]             cfg_data
);

  // principal point
  logic signed [hfl_pkg::HW-1:0] principal_x_r;
  logic signed [hfl_pkg::HW-1:0] principal_y_r;

  logic                          en;
  logic signed [hfl_pkg::HW-1:0] h [9];

  logic                          div_valid;
  logic [hfl_pkg::NUM_W-1:0]     div_num;
  logic [hfl_pkg::REM_W-1:0]     div_den;
  hfl_pkg::div_meta_t            div_meta;

  logic                          quo_valid;
  logic [hfl_pkg::NUM_W-1:0]     quo;
  hfl_pkg::div_meta_t            quo_meta;

  hfl_pkg::status_t              res_status;

  // whole pipeline advances unless the output word is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      principal_x_r <= '0;
      principal_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hfl_pkg::CFG_PRINCIPAL_X: principal_x_r <= cfg_data;
        hfl_pkg::CFG_PRINCIPAL_Y: principal_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    h[0] = in_h00;
    h[1] = in_h01;
    h[2] = in_h02;
    h[3] = in_h10;
    h[4] = in_h11;
    h[5] = in_h12;
    h[6] = in_h20;
    h[7] = in_h21;
    h[8] = in_h22;
  end

  // determinant, coefficient, right side
  hfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .h         (h),
    .u0        (principal_x_r),
    .v0        (principal_y_r),
    .div_valid (div_valid),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_meta  (div_meta)
  );

  // |b| << F divided by |a|
  hfl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .num       (div_num),
    .den       (div_den),
    .meta      (div_meta),
    .quo_valid (quo_valid),
    .quo       (quo),
    .quo_meta  (quo_meta)
  );

  // f2 = x - u0^2 - v0^2, then floor sqrt with saturation
  hfl_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (quo_valid),
    .quo        (quo),
    .meta       (quo_meta),
    .res_valid  (out_valid),
    .res_focal  (out_focal_length),
    .res_status (res_status)
  );

  assign out_status = res_status;

endmodule

FILE: tb/sv/tb_focal_length_from_homography_unit.sv
`timescale 1ns / 1ps

module tb_focal_length_from_homography_unit;

  localparam int LATENCY     = 6 + hfl_pkg::NUM_W + 2 + 32 + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 1300;
  localparam int NUM_PHASES  = 5;
  localparam int HOLD_CYCLES = 600;          // long receiver hold-off
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  // wide enough for every exact intermediate (b << F is under 2^115)
  typedef logic signed [199:0] wide_t;

  typedef struct {
    logic [31:0]      focal;
    hfl_pkg::status_t status;
  } focal_res_t;

  typedef struct {
    logic [31:0]      h [9];
    bit               typed;      // expected result written in the row
    logic [31:0]      focal;
    hfl_pkg::status_t status;
  } homog_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [31:0] in_h [9];
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [31:0]       out_focal_length;
  logic [1:0]        out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [hfl_pkg::CFG_IDX_W-1:0] cfg_index = hfl_pkg::CFG_PRINCIPAL_X;
  logic [31:0]       cfg_data = '0;

  // shadow of the principal point registers
  logic [31:0] pp_x = '0;
  logic [31:0] pp_y = '0;

  focal_res_t focal_fifo [$];   // results still owed by the block
  int errors = 0;
  int cycles = 0;
  int words_in = 0;
  int words_out = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit hold_req = 1'b0;
  int rx_calm = 0;

  initial for (int i = 0; i < 9; i++) in_h[i] = '0;

  always #5 clk = ~clk;

  focal_length_from_homography_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_h00(in_h[0]), .in_h01(in_h[1]), .in_h02(in_h[2]),
    .in_h10(in_h[3]), .in_h11(in_h[4]), .in_h12(in_h[5]),
    .in_h20(in_h[6]), .in_h21(in_h[7]), .in_h22(in_h[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_focal_length(out_focal_length), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // floor(sqrt(v)) for a 64-bit radicand
  function automatic logic [31:0] floor_sqrt64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // focal length of one homography under the current principal point
  function automatic focal_res_t focal_of_homography(input logic [31:0] hv [9]);
    wide_t h [9];
    wide_t u0, v0, det, a, q, su, sv, b, x, f2;
    focal_res_t r;
    for (int i = 0; i < 9; i++) h[i] = wide_t'($signed(hv[i]));
    u0 = wide_t'($signed(pp_x));
    v0 = wide_t'($signed(pp_y));
    r.focal = '0;
    det = h[0] * (h[4] * h[8] - h[5] * h[7]) - h[1] * (h[3] * h[8] - h[5] * h[6])
        + h[2] * (h[3] * h[7] - h[4] * h[6]);
    if (det < 0) begin
      r.status = hfl_pkg::ST_NEG_DET;
      return r;
    end
    a = h[7] * h[7] - h[6] * h[7] - h[6] * h[6];
    if (a == 0) begin
      r.status = hfl_pkg::ST_ZERO_COEF;
      return r;
    end
    q  = h[0] * h[1] + h[3] * h[4] + h[0] * h[0] + h[3] * h[3]
       - h[1] * h[1] - h[4] * h[4];
    su = u0 * (h[0] * h[7] + h[6] * h[1] + 2 * h[0] * h[6] - 2 * h[1] * h[7]);
    sv = v0 * (h[3] * h[7] + h[6] * h[4] + 2 * h[3] * h[6] - 2 * h[4] * h[7]);
    b  = (q <<< hfl_pkg::FRAC_BITS) - su - sv;
    x  = (b <<< hfl_pkg::FRAC_BITS) / a;          // truncates toward zero
    f2 = x - u0 * u0 - v0 * v0;
    if (f2 < 0) begin
      r.status = hfl_pkg::ST_NEG_F2;
      return r;
    end
    r.status = hfl_pkg::ST_OK;
    r.focal = (f2 >= (wide_t'(1) <<< 64)) ? 32'hFFFF_FFFF : floor_sqrt64(f2[63:0]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH @%0t word %0d: %s got 0x%08h want 0x%08h",
             $time, words_out, what, got, want);
  endtask

  // result checker: sample at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (focal_fifo.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(out_status), 32'hFFFF_FFFF);
      end else begin
        focal_res_t e;
        e = focal_fifo.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_focal_length !== e.focal)
          report_mismatch("focal_length", out_focal_length, e.focal);
        status_seen[e.status]++;
      end
      words_out++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, focal_fifo.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stall, calm stretches, one long hold-off on request
  initial begin
    bit held;
    int n;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (rx_calm > 0) begin
        rx_calm--;
        out_stall = 1'b0;
      end else if ($urandom_range(99) < 3) begin
        rx_calm = $urandom_range(300, 50);
        out_stall = 1'b0;
      end else begin
        n = gap_len();
        out_stall = (n != 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  // offer one homography word and wait for it to be taken
  task automatic send_homography(input logic [31:0] hv [9], input bit typed,
                                 input focal_res_t want);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    for (int i = 0; i < 9; i++) in_h[i] = hv[i];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    focal_fifo.push_back(typed ? want : focal_of_homography(hv));
    words_in++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every owed word is out, plus the pipeline depth
  task automatic drain();
    while (focal_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_principal(input logic [hfl_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [31:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hfl_pkg::CFG_PRINCIPAL_X) pp_x = val;
    else pp_y = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random entry: full range, small (within +-4.0), zero, or an extreme
  function automatic logic [31:0] rand_entry();
    int p;
    p = $urandom_range(99);
    if (p < 30) return $urandom();
    if (p < 85) return 32'($signed($urandom_range(8 * ONE)) - $signed(4 * ONE));
    if (p < 90) return 32'd0;
    if (p < 95) return MAXP;
    return MINN;
  endfunction

  function automatic logic [31:0] rand_principal();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 32'($signed($urandom_range(4 * ONE)) - $signed(2 * ONE));
    if (p < 80) return $urandom_range(ONE);
    return $urandom();
  endfunction

  homog_row_t dir_rows [$];

  task automatic add_row(input logic [31:0] h0, h1, h2, h3, h4, h5, h6, h7, h8,
                         input bit typed, input logic [31:0] focal,
                         input hfl_pkg::status_t st);
    homog_row_t r;
    r.h = '{h0, h1, h2, h3, h4, h5, h6, h7, h8};
    r.typed = typed;
    r.focal = focal;
    r.status = st;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [31:0] hv [9];
    focal_res_t none;
    logic [31:0] phase_px [NUM_PHASES];
    logic [31:0] phase_py [NUM_PHASES];
    none.focal = '0;
    none.status = hfl_pkg::ST_OK;

    // identity: zero coefficient since h20 = h21 = 0
    add_row(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 0, hfl_pkg::ST_ZERO_COEF);
    // mirror gives a negative determinant
    add_row(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 0, hfl_pkg::ST_NEG_DET);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, hfl_pkg::ST_ZERO_COEF);
    // q < 0 with a > 0: negative squared focal
    add_row(0, ONE, 0, 0, 0, 0, 0, ONE, ONE, 1, 0, hfl_pkg::ST_NEG_F2);
    // tiny coefficient, huge b: root saturates
    add_row(MAXP, 0, 0, 0, 0, 0, 0, 1, 0, 1, 32'hFFFF_FFFF, hfl_pkg::ST_OK);
    // well-formed case, f = sqrt(3)
    add_row(2 * ONE, 0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0, hfl_pkg::ST_OK);
    add_row(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 0, 0, hfl_pkg::ST_OK);
    add_row(MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, 0, 0, hfl_pkg::ST_OK);
    add_row(MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, 0, 0, hfl_pkg::ST_OK);
    add_row(MINN, MAXP, 0, MAXP, MINN, 0, MINN, MAXP, ONE, 0, 0, hfl_pkg::ST_OK);
    add_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1,
            0, 0, hfl_pkg::ST_OK);
    add_row(3 * ONE, ONE, 0, -ONE, 2 * ONE, 0, ONE / 2, ONE, ONE, 0, 0, hfl_pkg::ST_OK);
    add_row(ONE, 0, 0, 0, ONE, 0, ONE, 0, ONE, 0, 0, hfl_pkg::ST_OK);

    // principal point per phase: reset value first, then small values, extremes and random
    phase_px = '{32'd0, ONE, MAXP, MINN, rand_principal()};
    phase_py = '{32'd0, -2 * ONE, MINN, MAXP, rand_principal()};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      none.focal = dir_rows[i].focal;
      none.status = dir_rows[i].status;
      send_homography(dir_rows[i].h, dir_rows[i].typed, none);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph > 0) begin
        write_principal(hfl_pkg::CFG_PRINCIPAL_X, phase_px[ph]);
        write_principal(hfl_pkg::CFG_PRINCIPAL_Y, phase_py[ph]);
      end
      if (ph == 1) hold_req = 1'b1;    // receiver stops; pipeline fills up
      for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
        for (int i = 0; i < 9; i++) hv[i] = rand_entry();
        send_homography(hv, 0, none);
        if (ph == 2 && n == 100) drain();    // sender waits for an empty block
      end
    end
    drain();
    write_principal(hfl_pkg::CFG_PRINCIPAL_X, 32'd0);
    write_principal(hfl_pkg::CFG_PRINCIPAL_Y, 32'd0);
    drain();

    $display("Covered %0d homographies over %0d principal points, %0d results checked",
             words_in, NUM_PHASES, words_out);
    $display("Status mix: ok %0d, neg det %0d, neg f2 %0d, zero coef %0d",
             status_seen[hfl_pkg::ST_OK], status_seen[hfl_pkg::ST_NEG_DET],
             status_seen[hfl_pkg::ST_NEG_F2], status_seen[hfl_pkg::ST_ZERO_COEF]);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
src/hfl_pkg.sv
src/hfl_front.sv
src/hfl_div.sv
src/hfl_sqrt.sv
src/focal_length_from_homography_unit.sv
tb/sv/tb_focal_length_from_homography_unit.sv
